### sv/led_blink_controller_top_defines.svh
// Assertion macros shared by the LED blink controller checker.
// No dependencies; include by bare file name.
`ifndef LED_BLINK_CONTROLLER_TOP_DEFINES_SVH
`define LED_BLINK_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LBC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/lbc_pkg.sv
// Package for the LED blink controller: action codes, word types, constants.
// No dependencies.
`default_nettype none

package lbc_pkg;

  localparam int unsigned TickW = 16;

  // Blink count that never runs down.
  localparam logic [TickW-1:0] FOREVER_CODE = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_TICK          = 2'd0,
    ACT_SET_LEVEL     = 2'd1,
    ACT_BLINK         = 2'd2,
    ACT_BLINK_RESTART = 2'd3
  } lbc_action_e;

  // One input word.
  typedef struct packed {
    lbc_action_e      action;
    logic             level;
    logic [TickW-1:0] on_ticks;
    logic [TickW-1:0] off_ticks;
    logic [TickW-1:0] blink_count;
  } lbc_item_t;

  // One result word.
  typedef struct packed {
    logic pin_level;
    logic lit;
    logic busy_res;
  } lbc_result_t;

  // Handshake between the input stage and the output stage.
  typedef struct packed {
    logic advance;
    logic out_ready;
  } lbc_flow_t;

endpackage

`default_nettype wire

### sv/lbc_in_stage.sv
// Input register stage of the LED blink controller.
// Depends on lbc_pkg.
`default_nettype none

module lbc_in_stage import lbc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire lbc_item_t item_i,
  input  wire logic      out_ready_i,
  output lbc_item_t      item_o,
  output lbc_flow_t      flow_o
);

  logic      valid_q, valid_d;
  lbc_item_t item_q;
  logic      take;

  // A held word leaves when the output register can take it.
  assign flow_o.out_ready = out_ready_i;
  assign flow_o.advance   = valid_q && out_ready_i;
  assign in_stall_o       = valid_q && !out_ready_i;
  assign take             = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (flow_o.advance) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign item_o = item_q;

endmodule

`default_nettype wire

### sv/lbc_core.sv
// Blink state registers and their single-pass update for one word.
// Depends on lbc_pkg.
`default_nettype none

module lbc_core import lbc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      fire_i,
  input  wire lbc_item_t item_i,
  input  wire logic      active_high_i,
  output lbc_result_t    result_o
);

  logic             lit_q, lit_d;
  logic [TickW-1:0] blinks_q, blinks_d;
  logic [TickW-1:0] on_q, on_d;
  logic [TickW-1:0] off_q, off_d;
  logic [TickW-1:0] phase_q, phase_d;

  // Next state for the action of the current word.
  always_comb begin
    lit_d    = lit_q;
    blinks_d = blinks_q;
    on_d     = on_q;
    off_d    = off_q;
    phase_d  = phase_q;
    case (item_i.action)
      ACT_TICK: begin
        if (blinks_q != '0) begin
          if (phase_q > TickW'(1)) begin
            phase_d = phase_q - TickW'(1);
          end else if (lit_q) begin
            lit_d   = 1'b0;
            phase_d = off_q;
            if (blinks_q != FOREVER_CODE) begin
              blinks_d = blinks_q - TickW'(1);
            end
          end else begin
            lit_d   = 1'b1;
            phase_d = on_q;
          end
        end
      end
      ACT_SET_LEVEL: begin
        lit_d    = item_i.level;
        blinks_d = '0;
      end
      ACT_BLINK: begin
        blinks_d = item_i.blink_count;
        if (blinks_q == '0) begin
          lit_d   = 1'b1;
          on_d    = item_i.on_ticks;
          off_d   = item_i.off_ticks;
          phase_d = item_i.on_ticks;
        end
      end
      default: begin
        lit_d    = 1'b1;
        on_d     = item_i.on_ticks;
        off_d    = item_i.off_ticks;
        blinks_d = item_i.blink_count;
        phase_d  = item_i.on_ticks;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_q    <= 1'b0;
      blinks_q <= '0;
      on_q     <= '0;
      off_q    <= '0;
      phase_q  <= '0;
    end else if (fire_i) begin
      lit_q    <= lit_d;
      blinks_q <= blinks_d;
      on_q     <= on_d;
      off_q    <= off_d;
      phase_q  <= phase_d;
    end
  end

  // Result word taken after the update.
  assign result_o.lit       = lit_d;
  assign result_o.busy_res  = (blinks_d != '0);
  assign result_o.pin_level = (lit_d == active_high_i);

endmodule

`default_nettype wire

### sv/lbc_out_stage.sv
// Output register stage of the LED blink controller.
// Depends on lbc_pkg.
`default_nettype none

module lbc_out_stage import lbc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire lbc_flow_t   flow_i,
  input  wire lbc_result_t result_i,
  output logic             out_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output lbc_result_t      result_o
);

  logic        valid_q, valid_d;
  lbc_result_t result_q;

  // Room when empty or when the held word is taken this cycle.
  assign out_ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (flow_i.advance) begin
      valid_d = 1'b1;
    end else if (flow_i.out_ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_i.advance) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

### sv/led_blink_controller_top.sv
// Top level of the LED blink controller: input stage, blink core, output stage.
// Depends on lbc_pkg, lbc_in_stage, lbc_core and lbc_out_stage.
//
//   channel | direction | handshake               | word
//   in      | input     | in_valid_i / in_stall_o   | action, level, on/off ticks, count
//   out     | output    | out_valid_o / out_stall_i | pin_level, lit, busy_res
//   cfg     | input     | cfg_valid_i / cfg_ready_o | active_high
//
// One word per cycle is accepted while the output is not stalled; its result is
// offered from the output register once the word has left the input register.
// The blink state updates in one pass when a word moves from the input
// register into the output register.
// Reset leaves the LED dark, idle, with active_high set.
// A stalled output holds its word and backs up the input stage by one word.
`default_nettype none

module led_blink_controller_top import lbc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        in_action_i,
  input  wire logic              in_level_i,
  input  wire logic [TickW-1:0]  in_on_ticks_i,
  input  wire logic [TickW-1:0]  in_off_ticks_i,
  input  wire logic [TickW-1:0]  in_blink_count_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   out_pin_level_o,
  output logic                   out_lit_o,
  output logic                   out_busy_res_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic              cfg_active_high_i
);

  lbc_item_t   in_item, stage_item;
  lbc_flow_t   flow;
  lbc_result_t core_result, out_result;
  logic        out_ready;
  logic        active_high_q;

  // Polarity register; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_high_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      active_high_q <= cfg_active_high_i;
    end
  end

  // Gather the input fields into one word.
  assign in_item.action      = lbc_action_e'(in_action_i);
  assign in_item.level       = in_level_i;
  assign in_item.on_ticks    = in_on_ticks_i;
  assign in_item.off_ticks   = in_off_ticks_i;
  assign in_item.blink_count = in_blink_count_i;

  lbc_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .item_i      (in_item),
    .out_ready_i (out_ready),
    .item_o      (stage_item),
    .flow_o      (flow)
  );

  lbc_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (flow.advance),
    .item_i        (stage_item),
    .active_high_i (active_high_q),
    .result_o      (core_result)
  );

  lbc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .flow_i      (flow),
    .result_i    (core_result),
    .out_ready_o (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign out_pin_level_o = out_result.pin_level;
  assign out_lit_o       = out_result.lit;
  assign out_busy_res_o  = out_result.busy_res;

endmodule

`default_nettype wire

### sv/lbc_checker.sv
// Port-level checker for the LED blink controller, bound to the top level.
// Depends on lbc_pkg and led_blink_controller_top_defines.svh.
`default_nettype none
`include "led_blink_controller_top_defines.svh"

module lbc_port_checker import lbc_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic              out_pin_level_o,
  input wire logic              out_lit_o,
  input wire logic              out_busy_res_o,
  input wire logic              cfg_valid_i,
  input wire logic              cfg_ready_o,
  input wire logic              cfg_active_high_i
);

  logic ah_q;

  // Shadow of the polarity register, seen through the write channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ah_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ah_q <= cfg_active_high_i;
    end
  end

  // The input only backs up when the output holds a stalled word.
  `LBC_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled without output backpressure")

  // Pin level follows the lit state through the polarity register.
  `LBC_ASSERT_NOW(a_pin_polarity, clk_i, rst_ni, out_valid_o, out_pin_level_o == (out_lit_o == ah_q), "pin level disagrees with lit state and polarity")

  // A stalled result word holds still.
  `LBC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable({out_pin_level_o, out_lit_o, out_busy_res_o}), "stalled result word changed")

  // A word taken while the output is empty cannot leave the input backed up next cycle.
  `LBC_ASSERT_NEXT(a_latency, clk_i, rst_ni, in_valid_i && !in_stall_o && !out_valid_o, out_valid_o || !in_stall_o, "accepted word did not progress")

endmodule

bind led_blink_controller_top lbc_port_checker u_lbc_checker (.*);

`default_nettype wire

### tb/lbc_checker.sv
// Checker for the LED blink controller: watches the input, output and config channels,
// predicts each result word from its own copy of the blink state and compares them.
// Depends on lbc_pkg for the action codes and the word layouts.
`timescale 1ns / 1ps

module lbc_checker import lbc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_stall_i,
  input  wire logic [1:0]       in_action_i,
  input  wire logic             in_level_i,
  input  wire logic [TickW-1:0] in_on_ticks_i,
  input  wire logic [TickW-1:0] in_off_ticks_i,
  input  wire logic [TickW-1:0] in_blink_count_i,
  input  wire logic             out_valid_i,
  input  wire logic             out_stall_i,
  input  wire logic             out_pin_level_i,
  input  wire logic             out_lit_i,
  input  wire logic             out_busy_res_i,
  input  wire logic             cfg_valid_i,
  input  wire logic             cfg_ready_i,
  input  wire logic             cfg_active_high_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  // Predicted blink state and the polarity register.
  logic             polarity_high;
  logic             led_on;
  logic [TickW-1:0] blinks_remaining;
  logic [TickW-1:0] lit_len;
  logic [TickW-1:0] dark_len;
  logic [TickW-1:0] phase_left;

  // Result words still owed by the block, oldest first.
  lbc_result_t led_results_q[$];
  int          fail_cnt = 0;
  int          pending_cnt = 0;

  assign fail_count_o = fail_cnt;
  assign pending_o    = pending_cnt;

  // Load a fresh sequence: the LED lights and the lit phase starts.
  task automatic start_blinking(logic [TickW-1:0] on_t, logic [TickW-1:0] off_t,
                                logic [TickW-1:0] cnt);
    led_on           = 1'b1;
    lit_len          = on_t;
    dark_len         = off_t;
    blinks_remaining = cnt;
    phase_left       = on_t;
  endtask

  // One tick: count the phase down and toggle when it runs out.
  task automatic tick_led();
    if (blinks_remaining == '0) return;
    if (phase_left > 1) begin
      phase_left = phase_left - 1'b1;
    end else if (led_on) begin
      led_on = 1'b0;
      if (blinks_remaining != FOREVER_CODE) blinks_remaining = blinks_remaining - 1'b1;
      phase_left = dark_len;
    end else begin
      led_on     = 1'b1;
      phase_left = lit_len;
    end
  endtask

  // Apply one input word and work out the result word it produces.
  task automatic step_led(input lbc_item_t w, output lbc_result_t r);
    case (w.action)
      ACT_TICK: begin
        tick_led();
      end
      ACT_SET_LEVEL: begin
        led_on           = w.level;
        blinks_remaining = '0;
      end
      ACT_BLINK: begin
        // A running sequence only takes the new count.
        if (blinks_remaining != '0) blinks_remaining = w.blink_count;
        else start_blinking(w.on_ticks, w.off_ticks, w.blink_count);
      end
      default: begin
        start_blinking(w.on_ticks, w.off_ticks, w.blink_count);
      end
    endcase
    r.pin_level = (led_on == polarity_high);
    r.lit       = led_on;
    r.busy_res  = (blinks_remaining != '0);
  endtask

  // Count a failure; only the first few are printed in full.
  task automatic report_failure(string what, lbc_result_t want, lbc_result_t got);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("[%0t] %s: expected pin_level=%b lit=%b busy_res=%b, got pin_level=%b lit=%b busy_res=%b",
               $realtime, what, want.pin_level, want.lit, want.busy_res,
               got.pin_level, got.lit, got.busy_res);
    end
  endtask

  // Sample the channels at each rising edge; reset clears the predicted state.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    lbc_item_t   word_in;
    lbc_result_t want;
    lbc_result_t got;
    if (!rst_ni) begin
      polarity_high    = 1'b1;
      led_on           = 1'b0;
      blinks_remaining = '0;
      lit_len          = '0;
      dark_len         = '0;
      phase_left       = '0;
      led_results_q.delete();
      pending_cnt      = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) polarity_high = cfg_active_high_i;

      if (in_valid_i && !in_stall_i) begin
        word_in.action      = lbc_action_e'(in_action_i);
        word_in.level       = in_level_i;
        word_in.on_ticks    = in_on_ticks_i;
        word_in.off_ticks   = in_off_ticks_i;
        word_in.blink_count = in_blink_count_i;
        step_led(word_in, want);
        led_results_q.push_back(want);
      end

      if (out_valid_i && !out_stall_i) begin
        got.pin_level = out_pin_level_i;
        got.lit       = out_lit_i;
        got.busy_res  = out_busy_res_i;
        if (led_results_q.size() == 0) begin
          want = '0;
          report_failure("result word with no input pending", want, got);
        end else begin
          want = led_results_q.pop_front();
          if (got.pin_level !== want.pin_level || got.lit !== want.lit ||
              got.busy_res !== want.busy_res) begin
            report_failure("result word differs", want, got);
          end
        end
      end
      pending_cnt = led_results_q.size();
    end
  end

endmodule

### tb/tb_led_blink_controller_top.sv
// Testbench top for the LED blink controller: clock, reset, stimulus and the verdict.
// Depends on lbc_pkg, led_blink_controller_top and the lbc_checker module.
`timescale 1ns / 1ps

module tb_led_blink_controller_top;
  import lbc_pkg::*;

  localparam int CycleLimit = 300000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       in_action;
  logic             in_level;
  logic [TickW-1:0] in_on_ticks;
  logic [TickW-1:0] in_off_ticks;
  logic [TickW-1:0] in_blink_count;
  logic             out_valid;
  logic             out_stall;
  logic             out_pin_level;
  logic             out_lit;
  logic             out_busy_res;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_active_high;
  int               fail_count;
  int               pending;
  int               cycle_cnt = 0;
  int               calm_left = 0;

  led_blink_controller_top u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .in_action_i       (in_action),
    .in_level_i        (in_level),
    .in_on_ticks_i     (in_on_ticks),
    .in_off_ticks_i    (in_off_ticks),
    .in_blink_count_i  (in_blink_count),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .out_pin_level_o   (out_pin_level),
    .out_lit_o         (out_lit),
    .out_busy_res_o    (out_busy_res),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_active_high_i (cfg_active_high)
  );

  lbc_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .in_action_i       (in_action),
    .in_level_i        (in_level),
    .in_on_ticks_i     (in_on_ticks),
    .in_off_ticks_i    (in_off_ticks),
    .in_blink_count_i  (in_blink_count),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .out_pin_level_i   (out_pin_level),
    .out_lit_i         (out_lit),
    .out_busy_res_i    (out_busy_res),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_active_high_i (cfg_active_high),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  // 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("led_blink_controller_top: mismatch");
      $finish;
    end
  end

  // The receiver stalls at random except during the calm stretch.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= (calm_left == 0) && ($urandom_range(0, 99) < 19);
    end
  end

  // Phase lengths: mostly short so sequences finish, sometimes any 16-bit value.
  function automatic logic [TickW-1:0] pick_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return TickW'($urandom_range(0, 4));
    if (roll < 95) return TickW'($urandom_range(5, 12));
    return TickW'($urandom);
  endfunction

  // Blink counts: small ones, zero, forever, and the odd full-range value.
  function automatic logic [TickW-1:0] pick_count();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return TickW'($urandom_range(1, 3));
    if (roll < 65) return '0;
    if (roll < 80) return FOREVER_CODE;
    if (roll < 90) return TickW'($urandom_range(4, 20));
    return TickW'($urandom);
  endfunction

  // Offer one word, idling at random first, and hold it until it is taken.
  task automatic send_word(lbc_action_e act, logic lvl, logic [TickW-1:0] on_t,
                           logic [TickW-1:0] off_t, logic [TickW-1:0] cnt);
    while (calm_left == 0 && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_level       <= lvl;
    in_on_ticks    <= on_t;
    in_off_ticks   <= off_t;
    in_blink_count <= cnt;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (calm_left > 0) calm_left--;
  endtask

  // Stop sending and wait until every result word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the polarity register; only called while the block is idle.
  task automatic write_polarity(logic high);
    cfg_valid       <= 1'b1;
    cfg_active_high <= high;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed blink sequences followed by ticks, with some noise words.
  task automatic run_random(int n);
    int done_cnt;
    int k;
    int roll;
    done_cnt = 0;
    while (done_cnt < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        send_word($urandom_range(0, 1) ? ACT_BLINK_RESTART : ACT_BLINK,
                  1'($urandom_range(0, 1)), pick_len(), pick_len(), pick_count());
        k = $urandom_range(2, 25);
        repeat (k) begin
          roll = $urandom_range(0, 99);
          if (roll < 6) begin
            send_word(ACT_BLINK, 1'($urandom_range(0, 1)), TickW'($urandom),
                      TickW'($urandom), pick_count());
          end else if (roll < 9) begin
            send_word(ACT_SET_LEVEL, 1'($urandom_range(0, 1)), TickW'($urandom),
                      TickW'($urandom), TickW'($urandom));
          end else begin
            send_word(ACT_TICK, 1'($urandom_range(0, 1)), TickW'($urandom),
                      TickW'($urandom), TickW'($urandom));
          end
        end
        done_cnt += k + 1;
      end else begin
        send_word(lbc_action_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  TickW'($urandom), TickW'($urandom), TickW'($urandom));
        done_cnt++;
      end
    end
  endtask

  // Main sequence: reset, directed words, then three random phases.
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_action       = ACT_TICK;
    in_level        = 1'b0;
    in_on_ticks     = '0;
    in_off_ticks    = '0;
    in_blink_count  = '0;
    cfg_valid       = 1'b0;
    cfg_active_high = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    write_polarity(1'b1);

    // Tick while idle changes nothing, even with every other field set.
    send_word(ACT_TICK, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(ACT_SET_LEVEL, 1'b1, '0, '0, '0);
    send_word(ACT_SET_LEVEL, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // A blink with no count leaves the LED lit and ignores ticks.
    send_word(ACT_BLINK, 1'b0, 16'd3, 16'd2, '0);
    send_word(ACT_TICK, 1'b0, '0, '0, '0);
    send_word(ACT_TICK, 1'b1, '0, '0, '0);
    // A zero-length lit phase expires on the first tick.
    send_word(ACT_BLINK_RESTART, 1'b0, '0, 16'd1, 16'd1);
    send_word(ACT_TICK, 1'b0, '0, '0, '0);
    send_word(ACT_TICK, 1'b0, '0, '0, '0);
    // Longest phases with the forever count.
    send_word(ACT_BLINK_RESTART, 1'b1, 16'hFFFF, 16'hFFFF, FOREVER_CODE);
    send_word(ACT_TICK, 1'b0, '0, '0, '0);
    // A plain blink while busy only replaces the count; a zero count ends it.
    send_word(ACT_BLINK, 1'b0, 16'd1, 16'd1, 16'd3);
    send_word(ACT_TICK, 1'b0, '0, '0, '0);
    send_word(ACT_BLINK, 1'b1, 16'd1, 16'd1, '0);
    // Forever blinking with a zero-length dark phase toggles on every tick.
    send_word(ACT_BLINK_RESTART, 1'b0, 16'd1, '0, FOREVER_CODE);
    repeat (4) send_word(ACT_TICK, 1'b0, '0, '0, '0);
    // Set level stops a running sequence.
    send_word(ACT_SET_LEVEL, 1'b0, '0, '0, '0);
    send_word(ACT_TICK, 1'b0, '0, '0, '0);
    send_word(ACT_BLINK_RESTART, 1'b0, 16'd2, 16'd1, 16'd2);
    repeat (3) send_word(ACT_TICK, 1'b0, '0, '0, '0);
    wait_drained();

    write_polarity(1'b0);
    run_random(200);
    wait_drained();

    write_polarity(1'b1);
    calm_left = 70;
    run_random(200);
    wait_drained();

    write_polarity(1'b0);
    run_random(200);
    wait_drained();
    repeat (8) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("led_blink_controller_top: match");
    end else begin
      $display("led_blink_controller_top: mismatch");
    end
    $finish;
  end

endmodule
